>>> rtl/ptb_pkg.sv
`timescale 1ns / 1ps

package ptb_pkg;

    // field widths
    localparam int OP_W   = 3;
    localparam int ID_W   = 8;
    localparam int MODE_W = 2;
    localparam int DLY_W  = 32;
    localparam int STEP_W = 16;
    localparam int FIDX_W = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
    localparam logic [OP_W-1:0] OP_ENABLE  = 3'd2;
    localparam logic [OP_W-1:0] OP_DISABLE = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_DLY = 3'd4;

    // create modes
    localparam logic [MODE_W-1:0] MODE_ONESHOT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd1;

    // result kinds
    localparam logic EV_STATUS = 1'b0;
    localparam logic EV_FIRE   = 1'b1;

    // tick step after reset
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd10;

    // result of one count update
    typedef struct packed {
        logic             fire;
        logic [DLY_W-1:0] count;
    } upd_t;

endpackage

>>> rtl/ptb_count_update.sv
`timescale 1ns / 1ps

module ptb_count_update
    import ptb_pkg::*;
(
    input  logic [DLY_W-1:0]  count,
    input  logic [DLY_W-1:0]  delay,
    input  logic [STEP_W-1:0] step,
    output upd_t              upd
);

    logic [DLY_W:0]   sum;
    logic [DLY_W-1:0] sat;

    // saturating add of the step
    assign sum = {1'b0, count} + {{(DLY_W + 1 - STEP_W){1'b0}}, step};
    assign sat = sum[DLY_W] ? {DLY_W{1'b1}} : sum[DLY_W-1:0];

    // expire check, count restarts on fire
    assign upd.fire  = (sat >= delay);
    assign upd.count = upd.fire ? '0 : sat;

endmodule

>>> rtl/periodic_oneshot_timer_bank.sv
`timescale 1ns / 1ps

// Bank of TIMER_COUNT software-style timers. Create, enable, disable and
// set-delay beats each return one status beat (tlast set). A tick beat
// walks the delay and count memories one entry per cycle unless the
// result side stalls; the single read port of those memories sets this
// rate. Fire beats come in ascending timer index, the last one with tlast
// set; a tick that fires nothing returns no beat. Flags reset to inactive
// and one-shot and delays read as zero until written, so no clearing pass
// follows reset.
module periodic_oneshot_timer_bank
    import ptb_pkg::*;
#(
    parameter int TIMER_COUNT = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // timer_id[7:0], mode_code[9:8], delay_value[41:10]
    input  logic [2:0]  s_tuser,   // op[2:0]
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // failed[0], fired_index[4:1]
    output logic [0:0]  m_tuser,   // event_kind[0]
    output logic        m_tlast,
    // tick step register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CNT_W = $clog2(TIMER_COUNT + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TIMER_COUNT);
    localparam logic [ID_W:0]    ID_LIMIT = (ID_W + 1)'(TIMER_COUNT);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // input fields
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   timer_id;
    logic [MODE_W-1:0] mode_code;
    logic [DLY_W-1:0]  delay_value;

    assign op          = s_tuser[OP_W-1:0];
    assign timer_id    = s_tdata[7:0];
    assign mode_code   = s_tdata[9:8];
    assign delay_value = s_tdata[41:10];

    // state
    logic                   state_reg, state_next;
    logic [STEP_W-1:0]      tick_step_reg;
    logic [TIMER_COUNT-1:0] active_reg, active_next;
    logic [TIMER_COUNT-1:0] periodic_reg, periodic_next;
    logic [TIMER_COUNT-1:0] dly_vld_reg, dly_vld_next;
    logic [CNT_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0]       s1_idx_reg, s1_idx_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg, out_kind_next;
    logic                   out_failed_reg, out_failed_next;
    logic [FIDX_W-1:0]      out_fidx_reg, out_fidx_next;
    logic                   out_last_reg, out_last_next;

    // memories
    logic [DLY_W-1:0] delay_mem [TIMER_COUNT];
    logic [DLY_W-1:0] count_mem [TIMER_COUNT];
    logic [DLY_W-1:0] delay_rd_reg;
    logic [DLY_W-1:0] count_rd_reg;

    logic             in_accept;
    logic             out_free;
    logic             id_ok;
    logic [IDX_W-1:0] id_idx;
    logic             st_fail;
    logic             do_create, do_enable, do_disable, do_set_dly;
    logic             scan_more, issue, stall, advance, finish, s1_fire;
    logic [IDX_W-1:0] raddr;
    logic [DLY_W-1:0] delay_eff;
    upd_t             upd;
    logic             dly_we;
    logic             cnt_we;
    logic [IDX_W-1:0] cnt_waddr;
    logic [DLY_W-1:0] cnt_wdata;

    // handshakes
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_fidx_reg, out_failed_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // operation decode and checks
    assign id_ok  = ({1'b0, timer_id} < ID_LIMIT);
    assign id_idx = timer_id[IDX_W-1:0];

    always_comb
    begin
        st_fail    = 1'b1;
        do_create  = 1'b0;
        do_enable  = 1'b0;
        do_disable = 1'b0;
        do_set_dly = 1'b0;
        case (op)
            OP_TICK:
            begin
                st_fail = 1'b0;
            end
            OP_CREATE:
            begin
                if (id_ok && (mode_code inside {MODE_ONESHOT, MODE_PERIODIC}))
                begin
                    do_create = 1'b1;
                    st_fail   = 1'b0;
                end
            end
            OP_ENABLE:
            begin
                do_enable = id_ok;
                st_fail   = !id_ok;
            end
            OP_DISABLE:
            begin
                do_disable = id_ok;
                st_fail    = !id_ok;
            end
            OP_SET_DLY:
            begin
                do_set_dly = id_ok;
                st_fail    = !id_ok;
            end
            default:
            begin
                st_fail = 1'b1;
            end
        endcase
    end

    // scan control
    assign scan_more = (scan_idx_reg != LAST_CNT);
    assign raddr     = scan_idx_reg[IDX_W-1:0];
    assign delay_eff = dly_vld_reg[s1_idx_reg] ? delay_rd_reg : '0;

    ptb_count_update u_update (
        .count (count_rd_reg),
        .delay (delay_eff),
        .step  (tick_step_reg),
        .upd   (upd)
    );

    assign s1_fire = s1_valid_reg && upd.fire;
    assign stall   = s1_fire && pend_valid_reg && !out_free;
    assign issue   = (state_reg == ST_SCAN) && scan_more && !stall;
    assign advance = s1_valid_reg && !stall;
    assign finish  = (state_reg == ST_SCAN) && !scan_more && !s1_valid_reg
                     && (!pend_valid_reg || out_free);

    // memory write selection
    assign dly_we    = in_accept && (do_create || do_set_dly);
    assign cnt_we    = (in_accept && do_enable) || advance;
    assign cnt_waddr = advance ? s1_idx_reg : id_idx;
    assign cnt_wdata = advance ? upd.count : '0;

    // next state
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        s1_valid_next   = s1_valid_reg;
        s1_idx_next     = s1_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        active_next     = active_reg;
        periodic_next   = periodic_reg;
        dly_vld_next    = dly_vld_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_failed_next = out_failed_reg;
        out_fidx_next   = out_fidx_reg;
        out_last_next   = out_last_reg;

        // accepted input beats
        if (in_accept)
        begin
            if (op == OP_TICK)
            begin
                state_next    = ST_SCAN;
                scan_idx_next = '0;
            end
            else
            begin
                out_valid_next  = 1'b1;
                out_kind_next   = EV_STATUS;
                out_failed_next = st_fail;
                out_fidx_next   = '0;
                out_last_next   = 1'b1;
            end
            if (do_create)
            begin
                periodic_next[id_idx] = mode_code[0];
                dly_vld_next[id_idx]  = 1'b1;
            end
            if (do_set_dly)
            begin
                dly_vld_next[id_idx] = 1'b1;
            end
            if (do_enable)
            begin
                active_next[id_idx] = 1'b1;
            end
            if (do_disable)
            begin
                active_next[id_idx] = 1'b0;
            end
        end

        // read issue
        if (!stall)
        begin
            s1_valid_next = issue && active_reg[raddr];
        end
        if (issue)
        begin
            s1_idx_next   = raddr;
            scan_idx_next = scan_idx_reg + 1'b1;
        end

        // entry update, previous fire goes out once the next one is known
        if (advance && upd.fire)
        begin
            if (!periodic_reg[s1_idx_reg])
            begin
                active_next[s1_idx_reg] = 1'b0;
            end
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_kind_next   = EV_FIRE;
                out_failed_next = 1'b0;
                out_fidx_next   = FIDX_W'(pend_idx_reg);
                out_last_next   = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_idx_next   = s1_idx_reg;
        end

        // end of scan, flush the held fire as the last beat
        if (finish)
        begin
            state_next = ST_IDLE;
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_kind_next   = EV_FIRE;
                out_failed_next = 1'b0;
                out_fidx_next   = FIDX_W'(pend_idx_reg);
                out_last_next   = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_step_reg  <= STEP_RESET;
            active_reg     <= '0;
            periodic_reg   <= '0;
            dly_vld_reg    <= '0;
            scan_idx_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            periodic_reg   <= periodic_next;
            dly_vld_reg    <= dly_vld_next;
            scan_idx_reg   <= scan_idx_next;
            s1_valid_reg   <= s1_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                tick_step_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_idx_reg     <= s1_idx_next;
        pend_idx_reg   <= pend_idx_next;
        out_kind_reg   <= out_kind_next;
        out_failed_reg <= out_failed_next;
        out_fidx_reg   <= out_fidx_next;
        out_last_reg   <= out_last_next;
    end

    // delay memory
    always_ff @(posedge clk)
    begin
        if (dly_we)
        begin
            delay_mem[id_idx] <= delay_value;
        end
        if (issue)
        begin
            delay_rd_reg <= delay_mem[raddr];
        end
    end

    // count memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (issue)
        begin
            count_rd_reg <= count_mem[raddr];
        end
    end

    // checks
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!pend_valid_reg && !s1_valid_reg))
        else $error("scan pipeline not empty while idle");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_idx_reg <= LAST_CNT)
        else $error("scan index past the bank");

    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (op == OP_TICK)) |=> (state_reg == ST_SCAN))
        else $error("tick did not start a scan");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[0] == EV_STATUS)) |-> m_tlast)
        else $error("status beat without tlast");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> (s1_valid_reg && $stable(s1_idx_reg)))
        else $error("entry lost during stall");

endmodule
